[rtl/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define SMPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define SMPE_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[rtl/smpe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package smpe_pkg;

  // request codes
  localparam logic [4:0] REQ_SEL_VOICE    = 5'd0;
  localparam logic [4:0] REQ_ALL_VOICES   = 5'd1;
  localparam logic [4:0] REQ_MULTI_VOICES = 5'd2;
  localparam logic [4:0] REQ_ADD_VOICE    = 5'd3;
  localparam logic [4:0] REQ_SEL_PARAM    = 5'd4;
  localparam logic [4:0] REQ_ALL_PARAMS   = 5'd5;
  localparam logic [4:0] REQ_MULTI_PARAMS = 5'd6;
  localparam logic [4:0] REQ_ADD_PARAM    = 5'd7;
  localparam logic [4:0] REQ_TIME         = 5'd8;
  localparam logic [4:0] REQ_DEST_SIGNED  = 5'd9;
  localparam logic [4:0] REQ_DEST         = 5'd10;
  localparam logic [4:0] REQ_KEY_VOICE    = 5'd11;
  localparam logic [4:0] REQ_KEY_DOWN     = 5'd12;
  localparam logic [4:0] REQ_KEY_UP       = 5'd13;
  localparam logic [4:0] REQ_PRELOAD      = 5'd14;
  localparam logic [4:0] REQ_RESET        = 5'd15;
  localparam logic [4:0] REQ_REFRESH      = 5'd16;

  // status bytes
  localparam logic [7:0] ST_SEL_VOICE    = 8'h80;
  localparam logic [7:0] ST_MULTI_VOICES = 8'h90;
  localparam logic [7:0] ST_ADD_VOICE    = 8'hA0;
  localparam logic [7:0] ST_SEL_PARAM    = 8'h81;
  localparam logic [7:0] ST_MULTI_PARAMS = 8'h91;
  localparam logic [7:0] ST_ADD_PARAM    = 8'hA1;
  localparam logic [7:0] ST_TIME_SHORT   = 8'h82;
  localparam logic [7:0] ST_TIME_HIGH    = 8'hA2;
  localparam logic [7:0] ST_TIME_LOW     = 8'hB2;
  localparam logic [7:0] ST_SDEST_SHORT  = 8'h95;
  localparam logic [7:0] ST_DEST_SHORT   = 8'h85;
  localparam logic [7:0] ST_DEST_HIGH    = 8'hA5;
  localparam logic [7:0] ST_DEST_LOW     = 8'hB5;
  localparam logic [7:0] ST_KEY_VOICE    = 8'hB7;
  localparam logic [7:0] ST_KEY_DOWN     = 8'h97;
  localparam logic [7:0] ST_KEY_UP       = 8'h87;
  localparam logic [7:0] ST_PRELOAD      = 8'hAF;
  localparam logic [7:0] ST_RESET        = 8'hA7;

  // operand limits
  localparam logic [13:0] ID_MAX           = 14'h3FFE;
  localparam logic [13:0] ID_ALL           = 14'h3FFF;
  localparam logic [31:0] SHORT_MAX        = 32'h0000_3FFF;
  localparam logic [31:0] SHORT_SIGNED_MAX = 32'h0000_1FFF;
  localparam logic [27:0] TIME_MAX         = 28'hFFF_FFFF;
  localparam logic [26:0] DEST_MAX         = 27'h7FF_FFFF;

  // command queue depth
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one usb-midi event packet
  typedef struct packed {
    logic [7:0] status;
    logic [6:0] hi;
    logic [6:0] lo;
    logic       last;
  } pkt_t;

  // one classified request: one or two packets
  typedef struct packed {
    pkt_t pkt0;
    pkt_t pkt1;
    logic two;
  } cmd_t;

  function automatic pkt_t mk_pkt(logic [7:0] status, logic [6:0] hi, logic [6:0] lo,
                                  logic last);
    pkt_t p;
    p.status = status;
    p.hi     = hi;
    p.lo     = lo;
    p.last   = last;
    return p;
  endfunction

endpackage

`default_nettype wire

[rtl/synth_command_midi_packet_encoder.sv]
// the first packet of a request passes through the command queue, then the output packet register
// throughput: one packet per cycle while the receiver pops; one-packet requests every cycle,
//   two-packet requests one packet at a time, set by the output packet serializer
// a two-entry command queue lets the decoder run ahead of a stalled output
// reset: clears queue, output slot and all selection memory (no voice/param known)
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module synth_command_midi_packet_encoder import smpe_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [4:0]  req_type_i,
  input  wire logic [31:0] value_i,
  input  wire logic        steal_flag_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [3:0]       code_index_o,
  output logic [7:0]       status_byte_o,
  output logic [6:0]       data_high_o,
  output logic [6:0]       data_low_o,
  output logic             last_packet_o
);

  cmd_t wr_cmd, rd_cmd;
  logic q_wr, q_full, q_valid, q_rd;
  logic out_valid, out_pop;
  pkt_t out_pkt;

  // request decode and selection tracking
  smpe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .req_type_i  (req_type_i),
    .value_i     (value_i),
    .steal_flag_i(steal_flag_i),
    .q_full_i    (q_full),
    .q_wr_o      (q_wr),
    .q_cmd_o     (wr_cmd)
  );

  // command queue between decoder and serializer
  smpe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wr_cmd_i(wr_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .rd_cmd_o(rd_cmd),
    .rd_i    (q_rd)
  );

  // packet serializer with output register
  smpe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_cmd_i    (rd_cmd),
    .q_rd_o     (q_rd),
    .out_pop_i  (out_pop),
    .out_valid_o(out_valid),
    .out_pkt_o  (out_pkt)
  );

  assign full          = q_full;
  assign empty         = !out_valid;
  assign out_pop       = pop && out_valid;
  assign code_index_o  = out_pkt.status[7:4];
  assign status_byte_o = out_pkt.status;
  assign data_high_o   = out_pkt.hi;
  assign data_low_o    = out_pkt.lo;
  assign last_packet_o = out_pkt.last;

  // the second packet of a pair follows right after the first is taken
  `SMPE_ASSERT(a_pair_back_to_back, (pop && !empty && !last_packet_o) |=> !empty,
               "second packet of a pair not ready after first beat")
  // the leading packet of a pair always uses the a-row status
  `SMPE_ASSERT(a_pair_head_status, (!empty && !last_packet_o) |-> (status_byte_o[7:4] == 4'hA),
               "leading packet of a pair has wrong status row")
  // a shown packet always carries a status byte
  `SMPE_NEVER(a_status_range, !empty && (status_byte_o[7:6] != 2'b10),
              "status byte outside 0x80 to 0xBF")

endmodule

`default_nettype wire

[rtl/smpe_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module smpe_front import smpe_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire logic [4:0]  req_type_i,
  input  wire logic [31:0] value_i,
  input  wire logic        steal_flag_i,
  input  wire logic        q_full_i,
  output logic             q_wr_o,
  output cmd_t             q_cmd_o
);

  logic [13:0] lvid_q, lvid_d, lpid_q, lpid_d;
  logic        lvv_q, lvv_d, lpv_q, lpv_d;
  logic        vmul_q, vmul_d, pmul_q, pmul_d;

  logic        accept;
  logic        emit;
  logic [13:0] clip;
  logic        vmatch, pmatch;
  logic        neg;
  logic [31:0] mag;
  logic [27:0] tsat;
  logic [26:0] dsat, msat;

  assign accept = push_i && !q_full_i;

  // operand preparation
  always_comb begin
    clip   = (value_i > {18'd0, ID_MAX}) ? ID_MAX : value_i[13:0];
    vmatch = lvv_q && (value_i == {18'd0, lvid_q});
    pmatch = lpv_q && (value_i == {18'd0, lpid_q});
    tsat   = (value_i > {4'd0, TIME_MAX}) ? TIME_MAX : value_i[27:0];
    dsat   = (value_i > {5'd0, DEST_MAX}) ? DEST_MAX : value_i[26:0];
    neg    = value_i[31];
    mag    = neg ? (32'd0 - value_i) : value_i;
    msat   = (mag > {5'd0, DEST_MAX}) ? DEST_MAX : mag[26:0];
  end

  // classify request into packets and next selection state
  always_comb begin
    lvid_d = lvid_q;
    lvv_d  = lvv_q;
    lpid_d = lpid_q;
    lpv_d  = lpv_q;
    vmul_d = vmul_q;
    pmul_d = pmul_q;
    emit   = 1'b0;
    q_cmd_o.two  = 1'b0;
    q_cmd_o.pkt0 = mk_pkt(ST_SEL_VOICE, 7'd0, 7'd0, 1'b1);
    q_cmd_o.pkt1 = mk_pkt(ST_SEL_VOICE, 7'd0, 7'd0, 1'b1);
    case (req_type_i)
      REQ_SEL_VOICE: begin
        lvid_d = clip;
        lvv_d  = 1'b1;
        vmul_d = 1'b0;
        emit   = 1'b1;
        q_cmd_o.pkt0 = mk_pkt(ST_SEL_VOICE, clip[13:7], clip[6:0], 1'b1);
      end
      REQ_ALL_VOICES: begin
        vmul_d = 1'b1;
        emit   = 1'b1;
        q_cmd_o.pkt0 = mk_pkt(ST_SEL_VOICE, ID_ALL[13:7], ID_ALL[6:0], 1'b1);
      end
      REQ_MULTI_VOICES: begin
        if (!vmul_q) begin
          vmul_d = 1'b1;
          emit   = 1'b1;
        end
        q_cmd_o.pkt0 = mk_pkt(ST_MULTI_VOICES, clip[13:7], clip[6:0], 1'b1);
      end
      REQ_ADD_VOICE: begin
        if (!vmatch) begin
          vmul_d = 1'b1;
          emit   = 1'b1;
        end
        q_cmd_o.pkt0 = mk_pkt(ST_ADD_VOICE, clip[13:7], clip[6:0], 1'b1);
      end
      REQ_SEL_PARAM: begin
        if (pmul_q || !pmatch) begin
          lpid_d = clip;
          lpv_d  = 1'b1;
          pmul_d = 1'b0;
          emit   = 1'b1;
        end
        q_cmd_o.pkt0 = mk_pkt(ST_SEL_PARAM, clip[13:7], clip[6:0], 1'b1);
      end
      REQ_ALL_PARAMS: begin
        pmul_d = 1'b1;
        emit   = 1'b1;
        q_cmd_o.pkt0 = mk_pkt(ST_SEL_PARAM, ID_ALL[13:7], ID_ALL[6:0], 1'b1);
      end
      REQ_MULTI_PARAMS: begin
        if (!pmatch) begin
          pmul_d = 1'b1;
          emit   = 1'b1;
        end
        q_cmd_o.pkt0 = mk_pkt(ST_MULTI_PARAMS, clip[13:7], clip[6:0], 1'b1);
      end
      REQ_ADD_PARAM: begin
        if (!pmatch) begin
          pmul_d = 1'b1;
          emit   = 1'b1;
        end
        q_cmd_o.pkt0 = mk_pkt(ST_ADD_PARAM, clip[13:7], clip[6:0], 1'b1);
      end
      REQ_TIME: begin
        emit = 1'b1;
        if (value_i > SHORT_MAX) begin
          q_cmd_o.two  = 1'b1;
          q_cmd_o.pkt0 = mk_pkt(ST_TIME_HIGH, tsat[27:21], tsat[20:14], 1'b0);
          q_cmd_o.pkt1 = mk_pkt(ST_TIME_LOW, tsat[13:7], tsat[6:0], 1'b1);
        end else begin
          q_cmd_o.pkt0 = mk_pkt(ST_TIME_SHORT, value_i[13:7], value_i[6:0], 1'b1);
        end
      end
      REQ_DEST_SIGNED: begin
        emit = 1'b1;
        if (mag > SHORT_SIGNED_MAX) begin
          q_cmd_o.two  = 1'b1;
          q_cmd_o.pkt0 = mk_pkt(ST_DEST_HIGH, {neg, msat[26:21]}, msat[20:14], 1'b0);
          q_cmd_o.pkt1 = mk_pkt(ST_DEST_LOW, msat[13:7], msat[6:0], 1'b1);
        end else begin
          q_cmd_o.pkt0 = mk_pkt(ST_SDEST_SHORT, {neg, mag[12:7]}, mag[6:0], 1'b1);
        end
      end
      REQ_DEST: begin
        emit = 1'b1;
        if (value_i > SHORT_MAX) begin
          q_cmd_o.two  = 1'b1;
          q_cmd_o.pkt0 = mk_pkt(ST_DEST_HIGH, {1'b0, dsat[26:21]}, dsat[20:14], 1'b0);
          q_cmd_o.pkt1 = mk_pkt(ST_DEST_LOW, dsat[13:7], dsat[6:0], 1'b1);
        end else begin
          q_cmd_o.pkt0 = mk_pkt(ST_DEST_SHORT, value_i[13:7], value_i[6:0], 1'b1);
        end
      end
      REQ_KEY_VOICE: begin
        emit = 1'b1;
        q_cmd_o.pkt0 = mk_pkt(ST_KEY_VOICE, value_i[12:6], {value_i[5:0], steal_flag_i}, 1'b1);
      end
      REQ_KEY_DOWN: begin
        emit = 1'b1;
        q_cmd_o.pkt0 = mk_pkt(ST_KEY_DOWN, value_i[13:7], value_i[6:0], 1'b1);
      end
      REQ_KEY_UP: begin
        emit = 1'b1;
        q_cmd_o.pkt0 = mk_pkt(ST_KEY_UP, value_i[13:7], value_i[6:0], 1'b1);
      end
      REQ_PRELOAD: begin
        emit = 1'b1;
        q_cmd_o.pkt0 = mk_pkt(ST_PRELOAD, value_i[13:7], value_i[6:0], 1'b1);
      end
      REQ_RESET: begin
        emit = 1'b1;
        q_cmd_o.pkt0 = mk_pkt(ST_RESET, value_i[13:7], value_i[6:0], 1'b1);
      end
      REQ_REFRESH: begin
        lvv_d = 1'b0;
        lpv_d = 1'b0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign q_wr_o = accept && emit;

  // selection memory, updated on every accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvid_q <= '0;
      lvv_q  <= 1'b0;
      lpid_q <= '0;
      lpv_q  <= 1'b0;
      vmul_q <= 1'b0;
      pmul_q <= 1'b0;
    end else if (accept) begin
      lvid_q <= lvid_d;
      lvv_q  <= lvv_d;
      lpid_q <= lpid_d;
      lpv_q  <= lpv_d;
      vmul_q <= vmul_d;
      pmul_q <= pmul_d;
    end
  end

endmodule

`default_nettype wire

[rtl/smpe_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module smpe_queue import smpe_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_i,
  input  cmd_t      wr_cmd_i,
  output logic      full_o,
  output logic      valid_o,
  output cmd_t      rd_cmd_o,
  input  wire logic rd_i
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_wr, do_rd;

  assign full_o   = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o  = (cnt_q != '0);
  assign rd_cmd_o = mem_q[rptr_q];
  assign do_wr    = wr_i && !full_o;
  assign do_rd    = rd_i && valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_cmd_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/smpe_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module smpe_back import smpe_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_valid_i,
  input  cmd_t      q_cmd_i,
  output logic      q_rd_o,
  input  wire logic out_pop_i,
  output logic      out_valid_o,
  output pkt_t      out_pkt_o
);

  logic out_valid_q;
  pkt_t out_pkt_q, out_pkt_d;
  logic part_q;
  logic load;

  // pick next packet of the head command when the output slot frees up
  assign load      = q_valid_i && (!out_valid_q || out_pop_i);
  assign q_rd_o    = load && (part_q || !q_cmd_i.two);
  assign out_pkt_d = part_q ? q_cmd_i.pkt1 : q_cmd_i.pkt0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      part_q      <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      part_q      <= !part_q && q_cmd_i.two;
    end else if (out_pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output packet register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_pkt_q <= out_pkt_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pkt_o   = out_pkt_q;

endmodule

`default_nettype wire

[tb/sv/synth_command_midi_packet_encoder_tb.sv]
`timescale 1ns / 1ps

module synth_command_midi_packet_encoder_tb;
  import smpe_pkg::*;

  // one request as the sender sees it
  typedef struct packed {
    logic [4:0]  req;
    logic [31:0] value;
    logic        steal;
  } request_t;

  // a queued request plus the traffic shape it is sent under
  typedef struct {
    request_t    rq;
    int unsigned idle_pct;
    int unsigned stall_pct;
    bit          drain;
  } request_slot_t;

  // one usb-midi event beat
  typedef struct packed {
    logic [3:0] code;
    logic [7:0] status;
    logic [6:0] hi;
    logic [6:0] lo;
    logic       last;
  } midi_beat_t;

  localparam logic [4:0]  REQ_UNUSED_FIRST = REQ_REFRESH + 5'd1;
  localparam logic [4:0]  REQ_UNUSED_LAST  = 5'd31;
  localparam logic [31:0] SIGN_FLAG        = 32'h0000_0040;
  localparam int unsigned RANDOM_PER_PHASE = 232;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        push         = 1'b0;
  logic        full;
  logic [4:0]  req_type_i   = '0;
  logic [31:0] value_i      = '0;
  logic        steal_flag_i = 1'b0;
  logic        empty;
  logic        pop          = 1'b0;
  logic [3:0]  code_index_o;
  logic [7:0]  status_byte_o;
  logic [6:0]  data_high_o;
  logic [6:0]  data_low_o;
  logic        last_packet_o;

  // stimulus and expected beats
  request_slot_t requests_waiting[$];
  midi_beat_t    beats_due[$];
  int unsigned   recv_stall_pct = 0;

  // selection memory mirrored from the block
  logic [13:0] voice_id;
  logic        voice_known;
  logic [13:0] param_id;
  logic        param_known;
  logic        voices_multi;
  logic        params_multi;

  int unsigned requests_accepted = 0;
  int unsigned two_beat_requests = 0;
  int unsigned beats_checked     = 0;
  int unsigned mismatches        = 0;

  synth_command_midi_packet_encoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .req_type_i    (req_type_i),
    .value_i       (value_i),
    .steal_flag_i  (steal_flag_i),
    .empty         (empty),
    .pop           (pop),
    .code_index_o  (code_index_o),
    .status_byte_o (status_byte_o),
    .data_high_o   (data_high_o),
    .data_low_o    (data_low_o),
    .last_packet_o (last_packet_o)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("synth_command_midi_packet_encoder_tb failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
    end
  endtask

  function automatic logic [13:0] clip_id(input logic [31:0] v);
    return (v > {18'd0, ID_MAX}) ? ID_MAX : v[13:0];
  endfunction

  task automatic emit_beat(input logic [7:0] status, input logic [31:0] hi,
                           input logic [31:0] lo, input logic last);
    midi_beat_t b;
    b.code   = status[7:4];
    b.status = status;
    b.hi     = hi[6:0];
    b.lo     = lo[6:0];
    b.last   = last;
    beats_due.push_back(b);
  endtask

  task automatic emit_short(input logic [7:0] status, input logic [31:0] v);
    emit_beat(status, v >> 7, v, 1'b1);
  endtask

  // long form: upper half with optional sign, then lower half
  task automatic emit_long(input logic [7:0] st_high, input logic [7:0] st_low,
                           input logic [31:0] m, input logic [31:0] sign);
    emit_beat(st_high, (m >> 21) | sign, m >> 14, 1'b0);
    emit_beat(st_low, m >> 7, m, 1'b1);
    two_beat_requests++;
  endtask

  // predicts the beats one accepted request produces and updates selection memory
  task automatic encode_request(input logic [4:0] req, input logic [31:0] v,
                                input logic steal);
    logic [13:0] id;
    logic [31:0] mag;
    logic [31:0] sign;
    logic        voice_match;
    logic        param_match;
    id          = clip_id(v);
    mag         = v;
    sign        = '0;
    voice_match = voice_known && (v == {18'd0, voice_id});
    param_match = param_known && (v == {18'd0, param_id});
    case (req)
      REQ_SEL_VOICE: begin
        voice_id     = id;
        voice_known  = 1'b1;
        voices_multi = 1'b0;
        emit_short(ST_SEL_VOICE, {18'd0, id});
      end
      REQ_ALL_VOICES: begin
        voices_multi = 1'b1;
        emit_short(ST_SEL_VOICE, {18'd0, ID_ALL});
      end
      REQ_MULTI_VOICES: begin
        if (!voices_multi) begin
          voices_multi = 1'b1;
          emit_short(ST_MULTI_VOICES, {18'd0, id});
        end
      end
      REQ_ADD_VOICE: begin
        if (!voice_match) begin
          voices_multi = 1'b1;
          emit_short(ST_ADD_VOICE, {18'd0, id});
        end
      end
      REQ_SEL_PARAM: begin
        if (params_multi || !param_match) begin
          param_id     = id;
          param_known  = 1'b1;
          params_multi = 1'b0;
          emit_short(ST_SEL_PARAM, {18'd0, id});
        end
      end
      REQ_ALL_PARAMS: begin
        params_multi = 1'b1;
        emit_short(ST_SEL_PARAM, {18'd0, ID_ALL});
      end
      REQ_MULTI_PARAMS, REQ_ADD_PARAM: begin
        if (!param_match) begin
          params_multi = 1'b1;
          emit_short((req == REQ_MULTI_PARAMS) ? ST_MULTI_PARAMS : ST_ADD_PARAM,
                     {18'd0, id});
        end
      end
      REQ_TIME: begin
        if (v > SHORT_MAX) begin
          if (v > {4'd0, TIME_MAX}) mag = {4'd0, TIME_MAX};
          emit_long(ST_TIME_HIGH, ST_TIME_LOW, mag, '0);
        end else begin
          emit_short(ST_TIME_SHORT, v);
        end
      end
      REQ_DEST_SIGNED: begin
        // sign-magnitude; the most negative value saturates like any other
        if (v[31]) begin
          mag  = 32'd0 - v;
          sign = SIGN_FLAG;
        end
        if (mag > SHORT_SIGNED_MAX) begin
          if (mag > {5'd0, DEST_MAX}) mag = {5'd0, DEST_MAX};
          emit_long(ST_DEST_HIGH, ST_DEST_LOW, mag, sign);
        end else begin
          emit_beat(ST_SDEST_SHORT, (mag >> 7) | sign, mag, 1'b1);
        end
      end
      REQ_DEST: begin
        if (v > SHORT_MAX) begin
          if (v > {5'd0, DEST_MAX}) mag = {5'd0, DEST_MAX};
          emit_long(ST_DEST_HIGH, ST_DEST_LOW, mag, '0);
        end else begin
          emit_short(ST_DEST_SHORT, v);
        end
      end
      REQ_KEY_VOICE: emit_short(ST_KEY_VOICE, {31'd0, steal} + (v << 1));
      REQ_KEY_DOWN:  emit_short(ST_KEY_DOWN, v);
      REQ_KEY_UP:    emit_short(ST_KEY_UP, v);
      REQ_PRELOAD:   emit_short(ST_PRELOAD, v);
      REQ_RESET:     emit_short(ST_RESET, v);
      REQ_REFRESH: begin
        voice_known = 1'b0;
        param_known = 1'b0;
      end
      default: ;
    endcase
  endtask

  // driver: presents queued requests, predicts each one at acceptance
  always @(posedge clk_i or negedge rst_ni) begin : drive
    logic          next_push;
    request_slot_t slot;
    if (!rst_ni) begin
      push         <= 1'b0;
      req_type_i   <= '0;
      value_i      <= '0;
      steal_flag_i <= 1'b0;
    end else begin
      next_push = push;
      if (push && !full) begin
        encode_request(req_type_i, value_i, steal_flag_i);
        requests_accepted++;
        next_push = 1'b0;
      end
      if (!next_push && requests_waiting.size() != 0 &&
          !(requests_waiting[0].drain && beats_due.size() != 0) &&
          $urandom_range(99) >= requests_waiting[0].idle_pct) begin
        slot           = requests_waiting.pop_front();
        recv_stall_pct = slot.stall_pct;
        req_type_i   <= slot.rq.req;
        value_i      <= slot.rq.value;
        steal_flag_i <= slot.rq.steal;
        next_push      = 1'b1;
      end
      push <= next_push;
    end
  end

  // monitor: checks each popped beat against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : watch
    midi_beat_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        beats_checked++;
        if (beats_due.size() == 0) begin
          report_mismatch("beat with nothing pending", {24'd0, status_byte_o}, '0);
        end else begin
          want = beats_due.pop_front();
          if (code_index_o !== want.code)
            report_mismatch("code_index", {28'd0, code_index_o}, {28'd0, want.code});
          if (status_byte_o !== want.status)
            report_mismatch("status_byte", {24'd0, status_byte_o}, {24'd0, want.status});
          if (data_high_o !== want.hi)
            report_mismatch("data_high", {25'd0, data_high_o}, {25'd0, want.hi});
          if (data_low_o !== want.lo)
            report_mismatch("data_low", {25'd0, data_low_o}, {25'd0, want.lo});
          if (last_packet_o !== want.last)
            report_mismatch("last_packet", {31'd0, last_packet_o}, {31'd0, want.last});
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic add_request(input logic [4:0] req, input logic [31:0] v,
                             input logic steal, input int unsigned idle_pct,
                             input int unsigned stall_pct, input bit drain);
    request_slot_t slot;
    slot.rq.req    = req;
    slot.rq.value  = v;
    slot.rq.steal  = steal;
    slot.idle_pct  = idle_pct;
    slot.stall_pct = stall_pct;
    slot.drain     = drain;
    requests_waiting.push_back(slot);
  endtask

  // values on either side of every clipping and form boundary
  function automatic logic [31:0] corner_value(input int unsigned idx);
    case (idx)
      0:       return 32'h0000_0000;
      1:       return 32'h0000_1FFF;
      2:       return 32'h0000_2000;
      3:       return 32'h0000_3FFE;
      4:       return 32'h0000_3FFF;
      5:       return 32'h0000_4000;
      6:       return 32'h07FF_FFFF;
      7:       return 32'h0800_0000;
      8:       return 32'h0FFF_FFFF;
      9:       return 32'h1000_0000;
      10:      return 32'h7FFF_FFFF;
      11:      return 32'h8000_0000;
      12:      return 32'hF800_0001;
      13:      return 32'hFFFF_E001;
      14:      return 32'hFFFF_E000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // small ids dominate so that repeated selections hit the memory
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2: return $urandom_range(5);
      3, 4:    return corner_value($urandom_range(15));
      5:       return corner_value($urandom_range(15)) + $urandom_range(2) - 1;
      6:       return $urandom & 32'h0000_3FFF;
      7:       return 32'd0 - ($urandom & 32'h0000_3FFF);
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    int unsigned idle_pct;
    int unsigned stall_pct;
    logic [4:0]  req;

    voice_id     = '0;
    voice_known  = 1'b0;
    param_id     = '0;
    param_known  = 1'b0;
    voices_multi = 1'b0;
    params_multi = 1'b0;

    // directed: selection memory, clipping, both operand forms, saturation
    add_request(REQ_SEL_VOICE,    32'h0000_0000, 1'b0, 0, 0, 1'b0);
    add_request(REQ_ADD_VOICE,    32'h0000_0000, 1'b0, 0, 0, 1'b0);
    add_request(REQ_ADD_VOICE,    32'h0000_0005, 1'b0, 0, 0, 1'b0);
    add_request(REQ_MULTI_VOICES, 32'h0000_0007, 1'b0, 0, 0, 1'b0);
    add_request(REQ_SEL_VOICE,    32'hFFFF_FFFF, 1'b0, 0, 0, 1'b0);
    add_request(REQ_ADD_VOICE,    32'h0000_3FFE, 1'b0, 0, 0, 1'b0);
    add_request(REQ_MULTI_VOICES, 32'h0000_3FFF, 1'b0, 0, 0, 1'b0);
    add_request(REQ_ALL_VOICES,   32'h0000_0000, 1'b0, 0, 0, 1'b0);
    add_request(REQ_SEL_PARAM,    32'h0000_0007, 1'b0, 0, 0, 1'b0);
    add_request(REQ_SEL_PARAM,    32'h0000_0007, 1'b0, 0, 0, 1'b0);
    add_request(REQ_MULTI_PARAMS, 32'h0000_0007, 1'b0, 0, 0, 1'b0);
    add_request(REQ_ADD_PARAM,    32'h0000_0009, 1'b0, 0, 0, 1'b0);
    add_request(REQ_SEL_PARAM,    32'h0000_0007, 1'b0, 0, 0, 1'b0);
    add_request(REQ_ALL_PARAMS,   32'h0000_0000, 1'b0, 0, 0, 1'b0);
    add_request(REQ_REFRESH,      32'h0000_0000, 1'b0, 0, 0, 1'b0);
    add_request(REQ_ADD_PARAM,    32'h0000_0007, 1'b0, 0, 0, 1'b0);
    add_request(REQ_TIME,         32'h0000_3FFF, 1'b0, 0, 0, 1'b0);
    add_request(REQ_TIME,         32'h0000_4000, 1'b0, 0, 0, 1'b0);
    add_request(REQ_TIME,         32'hFFFF_FFFF, 1'b0, 0, 0, 1'b0);
    add_request(REQ_DEST_SIGNED,  32'h8000_0000, 1'b0, 0, 0, 1'b0);
    add_request(REQ_DEST_SIGNED,  32'hFFFF_E001, 1'b0, 0, 0, 1'b0);
    add_request(REQ_DEST,         32'hFFFF_FFFF, 1'b0, 0, 0, 1'b0);
    add_request(REQ_KEY_VOICE,    32'hFFFF_FFFF, 1'b1, 0, 0, 1'b0);
    add_request(REQ_KEY_DOWN,     32'hABCD_1234, 1'b0, 0, 0, 1'b0);
    add_request(REQ_KEY_UP,       32'h0000_3FFF, 1'b0, 0, 0, 1'b0);
    add_request(REQ_PRELOAD,      32'hFFFF_C001, 1'b0, 0, 0, 1'b0);
    add_request(REQ_RESET,        32'h5555_AAAA, 1'b0, 0, 0, 1'b0);
    add_request(REQ_UNUSED_LAST,  32'hFFFF_FFFF, 1'b1, 0, 0, 1'b0);

    // random: four traffic mixes, each opened by a full drain
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 61; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        if ($urandom_range(29) == 0) req = 5'($urandom_range(REQ_UNUSED_LAST, REQ_UNUSED_FIRST));
        else req = 5'($urandom_range(REQ_REFRESH, REQ_SEL_VOICE));
        add_request(req, pick_value(), 1'($urandom_range(1)), idle_pct, stall_pct,
                    (k == 0) || ($urandom_range(59) == 0));
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (requests_waiting.size() != 0 || push) @(posedge clk_i);
    while (beats_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("covered %0d requests over four idle/stall mixes, %0d of them two-beat;",
             requests_accepted, two_beat_requests);
    $display("%0d beats checked, %0d mismatches", beats_checked, mismatches);
    if (mismatches == 0) begin
      $display("synth_command_midi_packet_encoder_tb passed");
    end else begin
      $display("synth_command_midi_packet_encoder_tb failed");
    end
    $finish;
  end

endmodule
